/* design/hhn_pkg.sv */
// Shared types, constants and rate-table functions for the Hodgkin-Huxley neuron update.
// Used by every module of the block; depends on nothing else.
package hhn_pkg;

  localparam int NEURON_COUNT_DEF     = 1024;
  localparam int RATE_TABLE_DEPTH_DEF = 1024;

  localparam int IDX_W   = 10;
  localparam int VOLT_W  = 20;
  localparam int GATE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int DT_W    = 16;
  localparam int RATE_W  = 24;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 20;
  localparam int PIPE_LAST  = 7;

  localparam logic [CFG_ADDR_W-1:0] REG_TIME_STEP       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_THRESHOLD = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY_TIME = 2'd2;

  localparam logic [DT_W-1:0]          TIME_STEP_RST  = 16'd655;
  localparam logic signed [VOLT_W-1:0] THRESHOLD_RST  = 20'sd0;
  localparam logic [DT_W-1:0]          REFRACTORY_RST = 16'd512;

  localparam logic signed [VOLT_W-1:0] V_MIN   = -20'sd524288;
  localparam logic signed [VOLT_W-1:0] V_MAX   = 20'sd524287;
  localparam logic signed [VOLT_W-1:0] V_RESET = -20'sd16640;
  localparam logic signed [VOLT_W:0]   E_NA_Q8 = 21'sd12800;
  localparam logic signed [VOLT_W:0]   E_K_Q8  = -21'sd19712;
  localparam logic signed [VOLT_W:0]   E_L_Q8  = -21'sd13901;
  localparam logic signed [GATE_W-1:0] G_L_Q16 = 16'sd19661;

  localparam logic [GATE_W-1:0] GATE_M_RST = 16'd3277;
  localparam logic [GATE_W-1:0] GATE_H_RST = 16'd39322;
  localparam logic [GATE_W-1:0] GATE_N_RST = 16'd20972;

  localparam longint unsigned EINV_Q30 = 64'd395007542;
  localparam longint unsigned RATE_CAP = 64'hFFFFFF;

  typedef logic [RATE_W-1:0] rate_t;

  typedef struct packed {
    rate_t am;
    rate_t bm;
    rate_t ah;
    rate_t bh;
    rate_t an;
    rate_t bn;
  } rate_row_t;

  typedef struct packed {
    logic                     ever_fired;
    logic                     spike_flag;
    logic [TIME_W-1:0]        last_spike_at;
    logic [GATE_W-1:0]        gate_n;
    logic [GATE_W-1:0]        gate_h;
    logic [GATE_W-1:0]        gate_m;
    logic signed [VOLT_W-1:0] voltage;
  } nrn_state_t;

  // Per-item fields that ride along the pipeline.
  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic                     ok;
    logic [TIME_W-1:0]        now;
    logic signed [VOLT_W-1:0] v;
    logic [TIME_W-1:0]        last;
    logic                     ever;
  } carry_t;

  // Shift-subtract division, elaboration only.
  function automatic longint unsigned udiv(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^(-y) in Q30, y >= 0 in Q16
  function automatic longint unsigned eneg_q30(longint unsigned y_in);
    longint unsigned y, n, r, t, term, sum, steps;
    y = y_in;
    if (y > (64'd16 << 16)) y = 64'd16 << 16;
    n = y >> 16;
    r = y & 64'hFFFF;
    if (r == 0) begin
      sum = 64'd1 << 30;
      steps = n;
    end else begin
      t = 64'd65536 - r;
      term = 64'd1 << 30;
      sum = term;
      for (int k = 1; k <= 14; k++) begin
        term = udiv((term * t) >> 16, longint'(k));
        sum = sum + term;
      end
      steps = n + 1;
    end
    for (longint unsigned k = 0; k < steps; k++)
      sum = (sum * EINV_Q30 + (64'd1 << 29)) >> 30;
    return sum;
  endfunction

  // e^x in Q16, x in Q16
  function automatic longint unsigned exp_q16(longint x_in);
    longint x;
    longint unsigned d;
    x = x_in;
    if (x > (64'sd16 <<< 16)) x = 64'sd16 <<< 16;
    if (x < -(64'sd16 <<< 16)) x = -(64'sd16 <<< 16);
    if (x <= 0) return (eneg_q30(longint'(-x)) + (64'd1 << 13)) >> 14;
    d = eneg_q30(longint'(x));
    if (d == 0) return 64'hFFFFFFFF;
    return udiv((64'd1 << 46) + (d >> 1), d);
  endfunction

  // u / (1 - e^-u) in Q16, limit near zero
  function automatic longint unsigned xfrac(longint u);
    longint unsigned e, den;
    if (u > -1024 && u < 1024) return longint'(65536 + u / 2);
    e = exp_q16(-u);
    if (u > 0) begin
      den = 64'd65536 - e;
      if (den == 0) return 64'd65536;
      return udiv(longint'(u) * 64'd65536, den);
    end
    den = e - 64'd65536;
    if (den == 0) return 64'd65536;
    return udiv(longint'(-u) * 64'd65536, den);
  endfunction

  function automatic rate_t cap_rate(longint unsigned r);
    return (r > RATE_CAP) ? rate_t'(RATE_CAP) : rate_t'(r);
  endfunction

  function automatic rate_row_t rate_row(int i, int depth);
    rate_row_t row;
    longint vv, vq;
    vv = -64'sd32768 + longint'(udiv(longint'(i) * 64'd65536, longint'(depth)));
    vq = vv * 256;
    row.am = cap_rate(xfrac((vq + 40 * 65536) / 10));
    row.bm = cap_rate(64'd4 * exp_q16((-(vq + 65 * 65536)) / 18));
    row.ah = cap_rate(exp_q16((-(vq + 65 * 65536)) / 20) * 64'd7 / 64'd100);
    row.bh = cap_rate(udiv(64'd1 << 32, 64'd65536 + exp_q16((-(vq + 35 * 65536)) / 10)));
    row.an = cap_rate(xfrac((vq + 55 * 65536) / 10) / 64'd10);
    row.bn = cap_rate(exp_q16((-(vq + 65 * 65536)) / 80) / 64'd8);
    return row;
  endfunction

endpackage

/* design/hhn_rate_rom.sv */
// Voltage-indexed rate table for the six gate rate functions, registered read.
// Depends on hhn_pkg for the row type and the table builder.
module hhn_rate_rom #(
  parameter int DEPTH = hhn_pkg::RATE_TABLE_DEPTH_DEF,
  parameter int TW    = 10
) (
  input  logic               clk,
  input  logic               en,
  input  logic [TW-1:0]      ti,
  output hhn_pkg::rate_row_t row
);
  import hhn_pkg::*;

  rate_row_t rom_tab [DEPTH];
  rate_row_t row_r;

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_row
    localparam rate_row_t ROW = rate_row(gi, DEPTH);
    assign rom_tab[gi] = ROW;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= rom_tab[ti];
    end
  end

  assign row = row_r;

endmodule

/* design/hhn_gate_unit.sv */
// One gate's Euler step, pipelined over stages two to seven.
// Depends on hhn_pkg for widths; rates arrive from the rate table at stage three.
module hhn_gate_unit (
  input  logic                       clk,
  input  logic [7:2]                 en,
  input  logic [hhn_pkg::GATE_W-1:0] g_in,
  input  hhn_pkg::rate_t             rate_a,
  input  hhn_pkg::rate_t             rate_b,
  input  logic [hhn_pkg::DT_W-1:0]   dt,
  output logic [hhn_pkg::GATE_W-1:0] g_out
);
  import hhn_pkg::*;

  logic [GATE_W-1:0] g2_r, g3_r, g4_r, g5_r, g6_r, g7_r;
  logic [40:0]        pa4_r;
  logic [39:0]        pb4_r;
  logic signed [41:0] drive5_r;
  logic signed [58:0] prod6_r;
  logic signed [58:0] rsum;
  logic signed [27:0] ng;
  logic [GATE_W-1:0]  g7_nxt;

  // round to nearest, ties up, then saturate
  always_comb begin
    rsum = prod6_r + 59'sd2147483648;
    ng = $signed({12'd0, g6_r}) + 28'($signed(rsum[58:32]));
    if (ng < 0) begin
      g7_nxt = '0;
    end else if (ng > 28'sd65535) begin
      g7_nxt = '1;
    end else begin
      g7_nxt = ng[GATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) g2_r <= g_in;
    if (en[3]) g3_r <= g2_r;
    if (en[4]) begin
      g4_r  <= g3_r;
      pa4_r <= rate_a * (17'h10000 - {1'b0, g3_r});
      pb4_r <= rate_b * g3_r;
    end
    if (en[5]) begin
      g5_r     <= g4_r;
      drive5_r <= $signed({1'b0, pa4_r}) - $signed({2'b00, pb4_r});
    end
    if (en[6]) begin
      g6_r    <= g5_r;
      prod6_r <= drive5_r * $signed({1'b0, dt});
    end
    if (en[7]) g7_r <= g7_nxt;
  end

  assign g_out = g7_r;

endmodule

/* design/hhn_current.sv */
// Membrane current and scaled voltage change, pipelined over stages two to seven.
// Depends on hhn_pkg for widths and the reversal potentials and leak conductance.
module hhn_current (
  input  logic                              clk,
  input  logic [7:2]                        en,
  input  logic [hhn_pkg::GATE_W-1:0]        m_in,
  input  logic [hhn_pkg::GATE_W-1:0]        h_in,
  input  logic [hhn_pkg::GATE_W-1:0]        n_in,
  input  logic signed [hhn_pkg::VOLT_W-1:0] v_in,
  input  logic [hhn_pkg::DT_W-1:0]          dt,
  output logic signed [64:0]                vprod
);
  import hhn_pkg::*;

  logic [GATE_W-1:0] mm2_r, nn2_r, m2_r, h2_r, n2_r;
  logic [GATE_W-1:0] mmm3_r, nnn3_r, h3_r, n3_r;
  logic [GATE_W-1:0] m3h4_r, n44_r;
  logic signed [VOLT_W-1:0] v3_r, v4_r;
  logic signed [37:0] pna5_r, pk5_r;
  logic signed [36:0] pl5_r;
  logic signed [47:0] cur6_r;
  logic signed [64:0] vprod7_r;
  logic [31:0] mm_p, nn_p, mmm_p, nnn_p, m3h_p, n4_p;
  logic signed [VOLT_W:0] dna, dk, dl;

  always_comb begin
    mm_p  = m_in * m_in;
    nn_p  = n_in * n_in;
    mmm_p = mm2_r * m2_r;
    nnn_p = nn2_r * n2_r;
    m3h_p = mmm3_r * h3_r;
    n4_p  = nnn3_r * n3_r;
    dna   = $signed({v4_r[VOLT_W-1], v4_r}) - E_NA_Q8;
    dk    = $signed({v4_r[VOLT_W-1], v4_r}) - E_K_Q8;
    dl    = $signed({v4_r[VOLT_W-1], v4_r}) - E_L_Q8;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      mm2_r <= mm_p[31:16];
      nn2_r <= nn_p[31:16];
      m2_r  <= m_in;
      h2_r  <= h_in;
      n2_r  <= n_in;
    end
    if (en[3]) begin
      mmm3_r <= mmm_p[31:16];
      nnn3_r <= nnn_p[31:16];
      h3_r   <= h2_r;
      n3_r   <= n2_r;
      v3_r   <= v_in;
    end
    if (en[4]) begin
      m3h4_r <= m3h_p[31:16];
      n44_r  <= n4_p[31:16];
      v4_r   <= v3_r;
    end
    if (en[5]) begin
      pna5_r <= $signed({1'b0, m3h4_r}) * dna;
      pk5_r  <= $signed({1'b0, n44_r}) * dk;
      pl5_r  <= G_L_Q16 * dl;
    end
    // 120 = 128 - 8, 36 = 32 + 4
    if (en[6]) begin
      cur6_r <= (48'(pna5_r) <<< 7) - (48'(pna5_r) <<< 3)
              + (48'(pk5_r) <<< 5) + (48'(pk5_r) <<< 2) + 48'(pl5_r);
    end
    if (en[7]) vprod7_r <= (-cur6_r) * $signed({1'b0, dt});
  end

  assign vprod = vprod7_r;

endmodule

/* design/hodgkin_huxley_neuron_update.sv */
// Top level of the Hodgkin-Huxley neuron update: state memory, pipeline control, spike logic.
// Depends on hhn_pkg, hhn_rate_rom, hhn_gate_unit and hhn_current.
//
//   channel  direction  handshake            contents
//   in_      slave      tvalid/tready        tdata: neuron_index, voltage_increment, time_now
//   out_     master     tvalid/tready        tdata: neuron_id, new_voltage; tuser: fired
//   cfg_     write      cfg_we               cfg_addr selects register, cfg_wdata value
//
// One item per cycle while no hazard holds the input and out_ is not stalled; an item
// passes through the pipeline stages into the output register. The rate is set by the
// read-modify-write of the neuron state memory: an item whose neuron is still in flight
// waits until that earlier item writes back.
// After reset a clearing pass writes the reset state to all NEURON_COUNT entries, one a cycle,
// with in_tready low throughout. Each stage advances when the next is empty or
// moving, so a stall at out_ holds the pipeline without loss while bubbles still fill.
module hodgkin_huxley_neuron_update #(
  parameter int NEURON_COUNT     = hhn_pkg::NEURON_COUNT_DEF,
  parameter int RATE_TABLE_DEPTH = hhn_pkg::RATE_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] neuron_index, [29:10] voltage_increment, [61:30] time_now, [63:62] zero
  input  logic [hhn_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] neuron_id, [29:10] new_voltage, [31:30] zero
  output logic [hhn_pkg::OUT_DATA_W-1:0]    out_tdata,
  // [0] fired
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [hhn_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [hhn_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import hhn_pkg::*;

  localparam int AW = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
  localparam int TW = (RATE_TABLE_DEPTH > 1) ? $clog2(RATE_TABLE_DEPTH) : 1;

  // configuration registers
  logic [DT_W-1:0]          dt_r;
  logic signed [VOLT_W-1:0] thr_r;
  logic [DT_W-1:0]          refr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r   <= TIME_STEP_RST;
      thr_r  <= THRESHOLD_RST;
      refr_r <= REFRACTORY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TIME_STEP:       dt_r   <= cfg_wdata[DT_W-1:0];
        REG_SPIKE_THRESHOLD: thr_r  <= $signed(cfg_wdata[VOLT_W-1:0]);
        REG_REFRACTORY_TIME: refr_r <= cfg_wdata[DT_W-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [IDX_W-1:0]         in_idx;
  logic signed [VOLT_W-1:0] in_inc;
  logic [TIME_W-1:0]        in_now;
  logic [16:0]              in_idx_w;

  assign in_idx   = in_tdata[9:0];
  assign in_inc   = $signed(in_tdata[29:10]);
  assign in_now   = in_tdata[61:30];
  assign in_idx_w = 17'(in_idx);

  // pipeline control: stage k loads when it is empty or stage k+1 loads
  logic [PIPE_LAST:1]   vld_r;
  logic [PIPE_LAST+1:1] en;
  logic                 out_v_r;
  logic                 clr_r;
  logic [AW-1:0]        clr_cnt_r;
  logic                 hazard;
  logic                 accept;

  always_comb begin
    en[PIPE_LAST+1] = !out_v_r || out_tready;
    for (int k = PIPE_LAST; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // stage 1 registers
  logic [IDX_W-1:0]         idx1_r;
  logic                     ok1_r;
  logic signed [VOLT_W-1:0] inc1_r;
  logic [TIME_W-1:0]        now1_r;
  nrn_state_t               word1_r;
  carry_t                   p_r [2:PIPE_LAST];

  // hold the input while an earlier item for the same neuron has not written back
  always_comb begin
    hazard = vld_r[1] && ok1_r && (idx1_r == in_idx);
    for (int k = 2; k <= PIPE_LAST; k++) begin
      if (vld_r[k] && p_r[k].ok && (p_r[k].idx == in_idx)) hazard = 1'b1;
    end
  end

  assign in_tready = en[1] && !clr_r && !hazard;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= accept;
      for (int k = 2; k <= PIPE_LAST; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(NEURON_COUNT - 1)) clr_r <= 1'b0;
    end
  end

  // neuron state memory
  nrn_state_t mem [NEURON_COUNT];
  logic       mem_we;
  logic [AW-1:0] mem_wa;
  nrn_state_t mem_wd;
  nrn_state_t wb_word;
  nrn_state_t rst_word;

  assign rst_word = '{ever_fired: 1'b0, spike_flag: 1'b0, last_spike_at: '0,
                      gate_n: GATE_N_RST, gate_h: GATE_H_RST, gate_m: GATE_M_RST,
                      voltage: V_RESET};

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (en[1]) word1_r <= mem[in_idx_w[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      idx1_r <= in_idx;
      ok1_r  <= in_idx_w < 17'(NEURON_COUNT);
      inc1_r <= in_inc;
      now1_r <= in_now;
    end
  end

  // stage 1 -> 2: add the drive, saturate, find the table index
  logic signed [VOLT_W:0]   vsum;
  logic signed [VOLT_W-1:0] v_inc;
  logic signed [15:0]       vc;
  logic [TW+16:0]           ti_prod;
  logic [TW-1:0]            ti2_r;
  carry_t                   p2_nxt;

  always_comb begin
    vsum = $signed({word1_r.voltage[VOLT_W-1], word1_r.voltage})
         + $signed({inc1_r[VOLT_W-1], inc1_r});
    if (vsum > 21'(V_MAX)) begin
      v_inc = V_MAX;
    end else if (vsum < 21'(V_MIN)) begin
      v_inc = V_MIN;
    end else begin
      v_inc = vsum[VOLT_W-1:0];
    end
    if (v_inc < -20'sd32768) begin
      vc = -16'sd32768;
    end else if (v_inc > 20'sd32767) begin
      vc = 16'sd32767;
    end else begin
      vc = v_inc[15:0];
    end
    ti_prod = (TW+17)'(vc[15:0] ^ 16'h8000) * (TW+17)'(RATE_TABLE_DEPTH);
    p2_nxt.idx  = idx1_r;
    p2_nxt.ok   = ok1_r;
    p2_nxt.now  = now1_r;
    p2_nxt.v    = v_inc;
    p2_nxt.last = word1_r.last_spike_at;
    p2_nxt.ever = word1_r.ever_fired;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_r[2] <= p2_nxt;
      ti2_r  <= ti_prod[16 +: TW];
    end
    for (int k = 3; k <= PIPE_LAST; k++) begin
      if (en[k]) p_r[k] <= p_r[k-1];
    end
  end

  // rate table, gates and current
  rate_row_t         row3;
  logic [GATE_W-1:0] m7, h7, n7;
  logic signed [64:0] vprod7;

  hhn_rate_rom #(.DEPTH(RATE_TABLE_DEPTH), .TW(TW)) u_rom (
    .clk(clk), .en(en[3]), .ti(ti2_r), .row(row3)
  );

  hhn_gate_unit u_gate_m (
    .clk(clk), .en(en[7:2]), .g_in(word1_r.gate_m), .rate_a(row3.am), .rate_b(row3.bm),
    .dt(dt_r), .g_out(m7)
  );

  hhn_gate_unit u_gate_h (
    .clk(clk), .en(en[7:2]), .g_in(word1_r.gate_h), .rate_a(row3.ah), .rate_b(row3.bh),
    .dt(dt_r), .g_out(h7)
  );

  hhn_gate_unit u_gate_n (
    .clk(clk), .en(en[7:2]), .g_in(word1_r.gate_n), .rate_a(row3.an), .rate_b(row3.bn),
    .dt(dt_r), .g_out(n7)
  );

  hhn_current u_cur (
    .clk(clk), .en(en[7:2]), .m_in(word1_r.gate_m), .h_in(word1_r.gate_h),
    .n_in(word1_r.gate_n), .v_in(p_r[2].v), .dt(dt_r), .vprod(vprod7)
  );

  // stage 7: voltage step, spike test, write-back
  logic signed [64:0]       vr_sum;
  logic signed [33:0]       nv;
  logic signed [VOLT_W-1:0] v_step;
  logic                     fire;
  logic [TIME_W-1:0]        since;
  logic signed [VOLT_W-1:0] v_final;

  always_comb begin
    vr_sum = vprod7 + 65'sd2147483648;
    nv = 34'(p_r[PIPE_LAST].v) + 34'($signed(vr_sum[64:32]));
    if (nv > 34'(V_MAX)) begin
      v_step = V_MAX;
    end else if (nv < 34'(V_MIN)) begin
      v_step = V_MIN;
    end else begin
      v_step = nv[VOLT_W-1:0];
    end
    since = p_r[PIPE_LAST].now - p_r[PIPE_LAST].last;
    fire = p_r[PIPE_LAST].ok && (v_step > thr_r)
        && (!p_r[PIPE_LAST].ever || (since > TIME_W'(refr_r)));
    v_final = fire ? V_RESET : v_step;
    wb_word.ever_fired    = p_r[PIPE_LAST].ever || fire;
    wb_word.spike_flag    = fire;
    wb_word.last_spike_at = fire ? p_r[PIPE_LAST].now : p_r[PIPE_LAST].last;
    wb_word.gate_n        = n7;
    wb_word.gate_h        = h7;
    wb_word.gate_m        = m7;
    wb_word.voltage       = v_final;
  end

  // write back as the item moves into the output register; clearing owns the port first
  always_comb begin
    mem_we = clr_r || (en[PIPE_LAST+1] && vld_r[PIPE_LAST] && p_r[PIPE_LAST].ok);
    mem_wa = clr_r ? clr_cnt_r : AW'(17'(p_r[PIPE_LAST].idx));
    mem_wd = clr_r ? rst_word : wb_word;
  end

  // output register
  logic [IDX_W-1:0]         out_id_r;
  logic                     out_fired_r;
  logic signed [VOLT_W-1:0] out_volt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en[PIPE_LAST+1]) begin
      out_v_r <= vld_r[PIPE_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (en[PIPE_LAST+1]) begin
      out_id_r    <= p_r[PIPE_LAST].idx;
      out_fired_r <= fire;
      out_volt_r  <= p_r[PIPE_LAST].ok ? v_final : '0;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'b00, out_volt_r, out_id_r};
  assign out_tuser  = out_fired_r;

  // no transfer while the state memory is being cleared
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_tready)
    else $error("input taken during clearing pass");

  // a spike always leaves the neuron at its reset voltage
  a_fire_resets_voltage: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> ($signed(out_tdata[29:10]) == V_RESET))
    else $error("fired result without voltage reset");

  // an out-of-range neuron gives a zero voltage and no spike
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (17'(out_tdata[9:0]) >= 17'(NEURON_COUNT)))
      |-> (!out_tuser && (out_tdata[29:10] == '0)))
    else $error("out-of-range neuron changed the result");

endmodule
